// ----- hdl/dwc9_pkg.sv -----
`timescale 1ns / 1ps

package dwc9_pkg;

    localparam int TAP_COUNT  = 9;
    localparam int TAP_LOW    = 8;
    localparam int BYTE_W     = 8;
    localparam int ACC_W      = 32;
    localparam int MULT_W     = 31;
    localparam int PROD_W     = ACC_W + MULT_W;
    localparam int Q31_SHIFT  = 31;
    localparam int SHIFT_W    = 5;
    localparam int TAP_PROD_W = 18;
    localparam int PART_W     = TAP_PROD_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_ZP   = 3'd0,
        CFG_MULTIPLIER  = 3'd1,
        CFG_ROUNDING    = 3'd2,
        CFG_SHIFT       = 3'd3,
        CFG_OUTPUT_ZP   = 3'd4,
        CFG_CLAMP_LO    = 3'd5,
        CFG_CLAMP_HI    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  weight_offset;
        logic [MULT_W-1:0]  multiplier;
        logic [ACC_W-1:0]   rounding;
        logic [SHIFT_W-1:0] shift;
        logic [BYTE_W-1:0]  out_offset;
        logic [BYTE_W-1:0]  clamp_lo;
        logic [BYTE_W-1:0]  clamp_hi;
    } cfg_t;

    localparam logic [MULT_W-1:0] MULTIPLIER_RST = 31'h4000_0000;
    localparam logic [ACC_W-1:0]  ROUNDING_RST   = 32'h4000_0000;
    localparam logic [BYTE_W-1:0] CLAMP_HI_RST   = 8'hFF;

endpackage

// ----- hdl/dwc9_mac.sv -----
`timescale 1ns / 1ps

module dwc9_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [dwc9_pkg::BYTE_W-1:0]           weight_offset,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dwc9_pkg::TAP_LOW*dwc9_pkg::BYTE_W-1:0] pixel_taps_low,
    input  logic [dwc9_pkg::BYTE_W-1:0]           pixel_tap_eight,
    input  logic [dwc9_pkg::TAP_LOW*dwc9_pkg::BYTE_W-1:0] weight_taps_low,
    input  logic [dwc9_pkg::BYTE_W-1:0]           weight_tap_eight,
    input  logic signed [dwc9_pkg::ACC_W-1:0]     bias,
    output logic                                  acc_valid,
    input  logic                                  acc_ready,
    output logic [dwc9_pkg::ACC_W-1:0]            acc
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv;

    logic [dwc9_pkg::BYTE_W-1:0] px [dwc9_pkg::TAP_COUNT];
    logic [dwc9_pkg::BYTE_W-1:0] wt [dwc9_pkg::TAP_COUNT];

    logic signed [dwc9_pkg::TAP_PROD_W-1:0] prod_next [dwc9_pkg::TAP_COUNT];
    logic signed [dwc9_pkg::TAP_PROD_W-1:0] prod_reg  [dwc9_pkg::TAP_COUNT];
    logic signed [dwc9_pkg::ACC_W-1:0]      bias1_reg;

    logic signed [dwc9_pkg::PART_W-1:0] part_next [3];
    logic signed [dwc9_pkg::PART_W-1:0] part_reg  [3];
    logic signed [dwc9_pkg::ACC_W-1:0]  bias2_reg;

    logic [dwc9_pkg::ACC_W-1:0] acc_next;
    logic [dwc9_pkg::ACC_W-1:0] acc_reg;

    // a stage takes a new beat when it is empty or its beat moves on
    always_comb begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || acc_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign acc_valid = vld_reg[STAGES-1];
    assign acc       = acc_reg;

    always_comb begin
        for (int k = 0; k < dwc9_pkg::TAP_LOW; k++) begin
            px[k] = pixel_taps_low[k*dwc9_pkg::BYTE_W +: dwc9_pkg::BYTE_W];
            wt[k] = weight_taps_low[k*dwc9_pkg::BYTE_W +: dwc9_pkg::BYTE_W];
        end
        px[dwc9_pkg::TAP_LOW] = pixel_tap_eight;
        wt[dwc9_pkg::TAP_LOW] = weight_tap_eight;
    end

    always_comb begin
        logic signed [dwc9_pkg::BYTE_W:0] diff;
        logic signed [dwc9_pkg::BYTE_W:0] pxs;
        for (int k = 0; k < dwc9_pkg::TAP_COUNT; k++) begin
            diff = $signed({1'b0, wt[k]}) - $signed({1'b0, weight_offset});
            pxs  = $signed({1'b0, px[k]});
            prod_next[k] = dwc9_pkg::TAP_PROD_W'(pxs) * dwc9_pkg::TAP_PROD_W'(diff);
        end
    end

    // three partial sums of three taps each
    always_comb begin
        for (int g = 0; g < 3; g++) begin
            part_next[g] = dwc9_pkg::PART_W'(prod_reg[3*g])
                         + dwc9_pkg::PART_W'(prod_reg[3*g+1])
                         + dwc9_pkg::PART_W'(prod_reg[3*g+2]);
        end
    end

    // bias plus partial sums, wrapping at 32 bits
    assign acc_next = dwc9_pkg::ACC_W'(bias2_reg
                    + dwc9_pkg::ACC_W'(part_reg[0])
                    + dwc9_pkg::ACC_W'(part_reg[1])
                    + dwc9_pkg::ACC_W'(part_reg[2]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < STAGES; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_reg  <= prod_next;
            bias1_reg <= bias;
        end
        if (adv[1]) begin
            part_reg  <= part_next;
            bias2_reg <= bias1_reg;
        end
        if (adv[2]) begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- hdl/dwc9_requant.sv -----
`timescale 1ns / 1ps

module dwc9_requant (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dwc9_pkg::cfg_t                cfg,
    input  logic                          acc_valid,
    output logic                          acc_ready,
    input  logic [dwc9_pkg::ACC_W-1:0]    acc,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dwc9_pkg::BYTE_W-1:0]   out_value
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv;

    logic                        neg1_reg;
    logic [dwc9_pkg::ACC_W-1:0]  mag_next;
    logic [dwc9_pkg::ACC_W-1:0]  mag_reg;

    logic                        neg2_reg;
    logic [dwc9_pkg::PROD_W-1:0] prod_next;
    logic [dwc9_pkg::PROD_W-1:0] prod_reg;

    logic [63:0]                 sprod;
    logic [63:0]                 rsum;
    logic [dwc9_pkg::ACC_W-1:0]  q_next;
    logic [dwc9_pkg::ACC_W-1:0]  q_reg;

    logic [dwc9_pkg::ACC_W-1:0]  mask;
    logic [dwc9_pkg::ACC_W-1:0]  thr;
    logic [dwc9_pkg::ACC_W-1:0]  masked;
    logic                        round_up;
    logic signed [dwc9_pkg::ACC_W-1:0] shifted;
    logic signed [dwc9_pkg::ACC_W-1:0] r;
    logic signed [15:0]          v16_next;
    logic signed [15:0]          v16_reg;

    logic signed [16:0]          v17;
    logic [dwc9_pkg::BYTE_W-1:0] byte_sat;
    logic [dwc9_pkg::BYTE_W-1:0] byte_hi;
    logic [dwc9_pkg::BYTE_W-1:0] out_next;
    logic [dwc9_pkg::BYTE_W-1:0] out_reg;

    always_comb begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign acc_ready = adv[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_value = out_reg;

    // magnitude; the most negative value maps to 2^31, which still fits
    assign mag_next  = acc[dwc9_pkg::ACC_W-1] ? (dwc9_pkg::ACC_W'(0) - acc) : acc;

    assign prod_next = {{dwc9_pkg::MULT_W{1'b0}}, mag_reg}
                     * {{dwc9_pkg::ACC_W{1'b0}}, cfg.multiplier};

    // restore the sign, add rounding modulo 2^64, keep bits 62..31
    assign sprod  = neg2_reg ? (64'd0 - {1'b0, prod_reg}) : {1'b0, prod_reg};
    assign rsum   = sprod + {32'd0, cfg.rounding};
    assign q_next = rsum[dwc9_pkg::Q31_SHIFT +: dwc9_pkg::ACC_W];

    // rounding shift: negative values need a remainder one above the threshold
    always_comb begin
        mask     = ~(dwc9_pkg::ACC_W'(32'hFFFF_FFFF) << cfg.shift);
        thr      = mask >> 1;
        masked   = q_reg & mask;
        round_up = {1'b0, masked} > ({1'b0, thr} + {32'd0, q_reg[dwc9_pkg::ACC_W-1]});
        shifted  = $signed(q_reg) >>> cfg.shift;
        r        = shifted + $signed({31'd0, round_up});
        if (r > 32'sd32767) begin
            v16_next = 16'sh7FFF;
        end else if (r < -32'sd32768) begin
            v16_next = 16'sh8000;
        end else begin
            v16_next = r[15:0];
        end
    end

    always_comb begin
        v17 = {v16_reg[15], v16_reg} + $signed({9'd0, cfg.out_offset});
        if (v17 < 17'sd0) begin
            byte_sat = '0;
        end else if (v17 > 17'sd255) begin
            byte_sat = 8'hFF;
        end else begin
            byte_sat = v17[7:0];
        end
        byte_hi  = (byte_sat > cfg.clamp_hi) ? cfg.clamp_hi : byte_sat;
        // lower bound wins when the bounds cross
        out_next = (byte_hi < cfg.clamp_lo) ? cfg.clamp_lo : byte_hi;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < STAGES; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= (i == 0) ? acc_valid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            mag_reg  <= mag_next;
            neg1_reg <= acc[dwc9_pkg::ACC_W-1];
        end
        if (adv[1]) begin
            prod_reg <= prod_next;
            neg2_reg <= neg1_reg;
        end
        if (adv[2]) begin
            q_reg <= q_next;
        end
        if (adv[3]) begin
            v16_reg <= v16_next;
        end
        if (adv[4]) begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- hdl/depthwise_conv9_requant_u8_core.sv -----
`timescale 1ns / 1ps
// An accepted input beat reaches m_valid after passing through every register stage.
// One item per cycle while m_ready holds; eight register stages (three for the tap MAC,
// five for the 32x31 scaling multiply, rounding shift and clamp) form the pipeline.
// Backpressure stalls only stages that hold a beat, so bubbles still fill.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register defaults.

module depthwise_conv9_requant_u8_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dwc9_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dwc9_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [dwc9_pkg::TAP_LOW*dwc9_pkg::BYTE_W-1:0] s_pixel_taps_low,
    input  logic [dwc9_pkg::BYTE_W-1:0]            s_pixel_tap_eight,
    input  logic [dwc9_pkg::TAP_LOW*dwc9_pkg::BYTE_W-1:0] s_weight_taps_low,
    input  logic [dwc9_pkg::BYTE_W-1:0]            s_weight_tap_eight,
    input  logic signed [dwc9_pkg::ACC_W-1:0]      s_bias,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [dwc9_pkg::BYTE_W-1:0]            m_out_value
);

    dwc9_pkg::cfg_t cfg_reg;

    logic                       acc_valid;
    logic                       acc_ready;
    logic [dwc9_pkg::ACC_W-1:0] acc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.weight_offset <= '0;
            cfg_reg.multiplier    <= dwc9_pkg::MULTIPLIER_RST;
            cfg_reg.rounding      <= dwc9_pkg::ROUNDING_RST;
            cfg_reg.shift         <= '0;
            cfg_reg.out_offset    <= '0;
            cfg_reg.clamp_lo      <= '0;
            cfg_reg.clamp_hi      <= dwc9_pkg::CLAMP_HI_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (dwc9_pkg::cfg_index_t'(cfg_index))
                dwc9_pkg::CFG_KERNEL_ZP: begin
                    cfg_reg.weight_offset <= cfg_data[dwc9_pkg::BYTE_W-1:0];
                end
                dwc9_pkg::CFG_MULTIPLIER: begin
                    cfg_reg.multiplier <= cfg_data[dwc9_pkg::MULT_W-1:0];
                end
                dwc9_pkg::CFG_ROUNDING: begin
                    cfg_reg.rounding <= cfg_data[dwc9_pkg::ACC_W-1:0];
                end
                dwc9_pkg::CFG_SHIFT: begin
                    cfg_reg.shift <= cfg_data[dwc9_pkg::SHIFT_W-1:0];
                end
                dwc9_pkg::CFG_OUTPUT_ZP: begin
                    cfg_reg.out_offset <= cfg_data[dwc9_pkg::BYTE_W-1:0];
                end
                dwc9_pkg::CFG_CLAMP_LO: begin
                    cfg_reg.clamp_lo <= cfg_data[dwc9_pkg::BYTE_W-1:0];
                end
                dwc9_pkg::CFG_CLAMP_HI: begin
                    cfg_reg.clamp_hi <= cfg_data[dwc9_pkg::BYTE_W-1:0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    dwc9_mac u_mac (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .weight_offset     (cfg_reg.weight_offset),
        .in_valid          (s_valid),
        .in_ready          (s_ready),
        .pixel_taps_low    (s_pixel_taps_low),
        .pixel_tap_eight   (s_pixel_tap_eight),
        .weight_taps_low   (s_weight_taps_low),
        .weight_tap_eight  (s_weight_tap_eight),
        .bias              (s_bias),
        .acc_valid         (acc_valid),
        .acc_ready         (acc_ready),
        .acc               (acc)
    );

    dwc9_requant u_requant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc       (acc),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_value (m_out_value)
    );

    // an empty output stage lets every upstream stage advance
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output stage");

    a_out_above_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_value >= cfg_reg.clamp_lo))
        else $error("output below lower clamp");

    a_out_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (cfg_reg.clamp_lo <= cfg_reg.clamp_hi))
            |-> (m_out_value <= cfg_reg.clamp_hi))
        else $error("output above upper clamp");

    a_mac_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_valid && !acc_ready) |=> (acc_valid && $stable(acc)))
        else $error("accumulator beat lost while stalled");

endmodule
